/* hw/rtl/ddalr_pkg.sv */
`timescale 1ns / 1ps

package ddalr_pkg;

	localparam int COORD_RANGE_DEF = 512;
	localparam int FRAC_BITS_DEF   = 16;

	// input tuser: item kind
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// output tuser: result status
	localparam logic [1:0] ST_PIXEL   = 2'd0;
	localparam logic [1:0] ST_NO_LINE = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;

	typedef struct packed {
		logic start_line;
		logic reject;
		logic step;
		logic idle_step;
		logic out_load;
		logic div_run;
	} ddalr_cmd_t;

	typedef struct packed {
		logic is_step;
		logic bad_ends;
		logic dx_zero;
		logic step_final;
	} ddalr_stat_t;

endpackage

/* hw/rtl/dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// Every item's result is in the output register in the cycle after the item is taken.
// Step items and rejected starts: one item per cycle while the output is drained.
// A start with end x above start x then holds off input while the restoring divider
// forms the slope, one bit a cycle.
// arst_n clears the sequencer, the output valid flag and the active-line flag.
module dda_line_rasterizer #(
	parameter int COORD_RANGE = ddalr_pkg::COORD_RANGE_DEF,  // power of two
	parameter int FRAC_BITS   = ddalr_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// x_begin, y_begin, x_finish, y_finish
	input  logic [((4*$clog2(COORD_RANGE)+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pixel_x, pixel_y
	output logic [((2*$clog2(COORD_RANGE)+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0]            m_tuser,
	// final_pixel
	output logic                  m_tlast
);

	localparam int COORD_W = $clog2(COORD_RANGE);
	localparam int IN_W    = ((4 * COORD_W + 7) / 8) * 8;
	localparam int OUT_W   = ((2 * COORD_W + 7) / 8) * 8;

	ddalr_pkg::ddalr_cmd_t  cmd;
	ddalr_pkg::ddalr_stat_t stat;

	ddalr_ctrl #(
		.DIV_STEPS(COORD_W + FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ddalr_dpath #(
		.COORD_W   (COORD_W),
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (IN_W),
		.OUT_W     (OUT_W)
	) u_dpath (
		.clk     (clk),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

/* hw/rtl/ddalr_ctrl.sv */
`timescale 1ns / 1ps

module ddalr_ctrl #(
	parameter int DIV_STEPS = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  ddalr_pkg::ddalr_stat_t stat,
	output ddalr_pkg::ddalr_cmd_t  cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic {
		IDLE,
		DIVIDE
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic             line_active_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	// output slot must be free (or freeing) before an item is taken
	assign s_tready = (state_q == IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.start_line = accept && !stat.is_step && !stat.bad_ends;
		cmd.reject     = accept && !stat.is_step && stat.bad_ends;
		cmd.step       = accept && stat.is_step && line_active_q;
		cmd.idle_step  = accept && stat.is_step && !line_active_q;
		cmd.out_load   = accept;
		cmd.div_run    = (state_q == DIVIDE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			out_valid_q   <= 1'b0;
			line_active_q <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd.reject) begin
						line_active_q <= 1'b0;
					end else if (cmd.start_line) begin
						line_active_q <= !stat.dx_zero;
						if (!stat.dx_zero) begin
							state_q <= DIVIDE;
							cnt_q   <= CNT_W'(DIV_STEPS - 1);
						end
					end else if (cmd.step && stat.step_final) begin
						line_active_q <= 1'b0;
					end
				end
				DIVIDE: begin
					if (cnt_q == '0) begin
						state_q <= IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			endcase
		end
	end

endmodule

/* hw/rtl/ddalr_dpath.sv */
`timescale 1ns / 1ps

module ddalr_dpath #(
	parameter int COORD_W   = 9,
	parameter int FRAC_BITS = 16,
	parameter int IN_W      = 40,
	parameter int OUT_W     = 24
) (
	input  logic                   clk,
	input  logic [IN_W-1:0]        s_tdata,
	input  logic                   s_tuser,
	input  ddalr_pkg::ddalr_cmd_t  cmd,
	output ddalr_pkg::ddalr_stat_t stat,
	output logic [OUT_W-1:0]       m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	localparam int SLOPE_W = COORD_W + FRAC_BITS;
	localparam int ACC_W   = COORD_W + 1 + FRAC_BITS;

	logic [COORD_W-1:0] xb, yb, xf, yf;
	logic [COORD_W-1:0] dy;
	logic [COORD_W-1:0] cur_x_q, stop_x_q, next_x;
	logic [ACC_W-1:0]   acc_q, acc_step, acc_start, acc_sel;
	logic [ACC_W:0]     round_sum;
	logic [COORD_W-1:0] py_calc;
	logic [SLOPE_W-1:0] quo_q;   // dividend shift-in during divide, slope after
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] dvs_q;
	logic [COORD_W:0]   shifted;
	logic [COORD_W+1:0] diff;
	logic               take;
	logic [COORD_W-1:0] px_q, py_q;
	logic               fin_q;
	logic [1:0]         st_q;

	assign xb = s_tdata[COORD_W-1:0];
	assign yb = s_tdata[2*COORD_W-1:COORD_W];
	assign xf = s_tdata[3*COORD_W-1:2*COORD_W];
	assign yf = s_tdata[4*COORD_W-1:3*COORD_W];
	assign dy = yf - yb;

	assign next_x    = cur_x_q + 1'b1;
	assign acc_step  = acc_q + ACC_W'(quo_q);
	assign acc_start = ACC_W'({yb, {FRAC_BITS{1'b0}}});
	assign acc_sel   = cmd.step ? acc_step : acc_start;

	// round to nearest: add one half, keep the integer bits
	assign round_sum = {1'b0, acc_sel}
		+ {{(ACC_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	assign py_calc   = round_sum[FRAC_BITS+COORD_W-1:FRAC_BITS];

	// restoring divider, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[SLOPE_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign take    = !diff[COORD_W+1];

	always_comb begin
		stat.is_step    = (s_tuser == ddalr_pkg::CMD_STEP);
		stat.bad_ends   = (xf < xb) || (yf < yb);
		stat.dx_zero    = (xf == xb);
		stat.step_final = (next_x == stop_x_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.start_line) begin
			cur_x_q  <= xb;
			stop_x_q <= xf;
			acc_q    <= acc_start;
			rem_q    <= '0;
			dvs_q    <= xf - xb;
			quo_q    <= stat.dx_zero ? '0 : {dy, {FRAC_BITS{1'b0}}};
		end else if (cmd.step) begin
			cur_x_q <= next_x;
			acc_q   <= acc_step;
		end else if (cmd.div_run) begin
			rem_q <= take ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
			quo_q <= {quo_q[SLOPE_W-2:0], take};
		end

		if (cmd.out_load) begin
			priority if (cmd.start_line) begin
				px_q  <= xb;
				py_q  <= py_calc;
				fin_q <= stat.dx_zero;
				st_q  <= ddalr_pkg::ST_PIXEL;
			end else if (cmd.step) begin
				px_q  <= next_x;
				py_q  <= py_calc;
				fin_q <= stat.step_final;
				st_q  <= ddalr_pkg::ST_PIXEL;
			end else if (cmd.reject) begin
				px_q  <= '0;
				py_q  <= '0;
				fin_q <= 1'b0;
				st_q  <= ddalr_pkg::ST_REJECT;
			end else begin
				px_q  <= '0;
				py_q  <= '0;
				fin_q <= 1'b0;
				st_q  <= ddalr_pkg::ST_NO_LINE;
			end
		end
	end

	assign m_tdata = OUT_W'({py_q, px_q});
	assign m_tuser = st_q;
	assign m_tlast = fin_q;

endmodule

/* hw/rtl/ddalr_checker.sv */
`timescale 1ns / 1ps

module ddalr_checker #(
	parameter int COORD_RANGE = ddalr_pkg::COORD_RANGE_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [((4*$clog2(COORD_RANGE)+7)/8)*8-1:0] s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [((2*$clog2(COORD_RANGE)+7)/8)*8-1:0] m_tdata,
	input logic [1:0]            m_tuser,
	input logic                  m_tlast
);

	localparam int CW = $clog2(COORD_RANGE);

	// a blocked result keeps the input closed
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted item");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ddalr_pkg::ST_PIXEL) |-> (m_tdata == '0) && !m_tlast)
		else $error("error result carries pixel data");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ddalr_pkg::CMD_START)
		&& (s_tdata[3*CW-1:2*CW] < s_tdata[CW-1:0])
		|=> m_tvalid && (m_tuser == ddalr_pkg::ST_REJECT))
		else $error("backward line not rejected");

	a_stall_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind dda_line_rasterizer ddalr_checker #(.COORD_RANGE(COORD_RANGE)) u_ddalr_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam logic       CMD_START  = ddalr_pkg::CMD_START;
	localparam logic       CMD_STEP   = ddalr_pkg::CMD_STEP;
	localparam logic [1:0] ST_PIXEL   = ddalr_pkg::ST_PIXEL;
	localparam logic [1:0] ST_NO_LINE = ddalr_pkg::ST_NO_LINE;
	localparam logic [1:0] ST_REJECT  = ddalr_pkg::ST_REJECT;

	localparam int CW      = $clog2(ddalr_pkg::COORD_RANGE_DEF);
	localparam int FB      = ddalr_pkg::FRAC_BITS_DEF;
	localparam int IN_W    = ((4*CW+7)/8)*8;
	localparam int OUT_W   = ((2*CW+7)/8)*8;
	localparam int ACC_W   = CW + FB + 1;
	localparam int SLOPE_W = CW + FB;
	localparam int CMAX    = ddalr_pkg::COORD_RANGE_DEF - 1;
	localparam int RAND_ITEMS = 1400;
	localparam int HOLD_CYC   = 300;
	localparam int DIR_N      = 24;

	typedef struct packed {
		logic          kind;
		logic [CW-1:0] xb;
		logic [CW-1:0] yb;
		logic [CW-1:0] xf;
		logic [CW-1:0] yf;
	} line_cmd_t;

	typedef struct packed {
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic          fin;
		logic [1:0]    status;
	} pixel_t;

	// typed = 1: use want as is, otherwise the predictor supplies it
	typedef struct packed {
		line_cmd_t it;
		logic      typed;
		pixel_t    want;
	} dir_row_t;

	localparam logic [CW-1:0] XM = CW'(CMAX);

	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_NO_LINE}},
		'{'{CMD_START, 9'd0,   9'd0,   XM,     XM},     1'b1, '{9'd0, 9'd0, 1'b0, ST_PIXEL}},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_START, 9'd10,  9'd0,   9'd5,   9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_REJECT}},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_NO_LINE}},
		'{'{CMD_START, 9'd0,   9'd10,  9'd5,   9'd5},   1'b1, '{9'd0, 9'd0, 1'b0, ST_REJECT}},
		'{'{CMD_START, 9'd7,   9'd9,   9'd7,   9'd300}, 1'b1, '{9'd7, 9'd9, 1'b1, ST_PIXEL}},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_NO_LINE}},
		'{'{CMD_START, 9'd0,   9'd0,   9'd3,   9'd1},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  XM,     XM,     XM,     XM},     1'b1, '{9'd0, 9'd0, 1'b0, ST_NO_LINE}},
		'{'{CMD_START, XM,     XM,     XM,     XM},     1'b1, '{XM, XM, 1'b1, ST_PIXEL}},
		'{'{CMD_START, 9'd508, 9'd0,   XM,     XM},     1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_START, 9'd100, 9'd0,   9'd101, XM},     1'b0, '0},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b0, '0},
		'{'{CMD_START, XM,     9'd0,   9'd0,   XM},     1'b1, '{9'd0, 9'd0, 1'b0, ST_REJECT}},
		'{'{CMD_START, 9'd0,   XM,     XM,     9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_REJECT}},
		'{'{CMD_STEP,  9'd0,   9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 1'b0, ST_NO_LINE}}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;
	logic             m_tlast;

	// line tracker state
	logic [CW-1:0]      ln_x = '0;
	logic [ACC_W-1:0]   ln_acc = '0;
	logic [SLOPE_W-1:0] ln_slope = '0;
	logic [CW-1:0]      ln_stop = '0;
	logic               ln_on = 1'b0;

	pixel_t pixel_q[$];
	int     err_cnt = 0;
	int     items_sent = 0;
	int     burst_left = 0;
	bit     hold_req = 1'b0;

	always #1 clk = ~clk;

	dda_line_rasterizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic logic [CW-1:0] round_y(logic [ACC_W-1:0] acc);
		logic [ACC_W:0] t;
		t = acc + (ACC_W+1)'(1 << (FB-1));
		return t[FB +: CW];
	endfunction

	function automatic pixel_t next_pixel(line_cmd_t it);
		pixel_t        r;
		logic [CW-1:0] dx;
		logic [CW-1:0] dy;
		r = '0;
		if (it.kind == CMD_START) begin
			if (it.xf < it.xb || it.yf < it.yb) begin
				ln_on = 1'b0;
				r.status = ST_REJECT;
			end else begin
				dx = it.xf - it.xb;
				dy = it.yf - it.yb;
				ln_slope = (dx == '0) ? '0 : SLOPE_W'({dy, {FB{1'b0}}} / dx);
				ln_x = it.xb;
				ln_stop = it.xf;
				ln_acc = {1'b0, it.yb, {FB{1'b0}}};
				ln_on = (dx != '0);
				r.px = ln_x;
				r.py = round_y(ln_acc);
				r.fin = (dx == '0);
				r.status = ST_PIXEL;
			end
		end else if (!ln_on) begin
			r.status = ST_NO_LINE;
		end else begin
			ln_x = ln_x + 1'b1;
			ln_acc = ln_acc + ACC_W'(ln_slope);
			r.fin = (ln_x == ln_stop);
			if (r.fin)
				ln_on = 1'b0;
			r.px = ln_x;
			r.py = round_y(ln_acc);
			r.status = ST_PIXEL;
		end
		return r;
	endfunction

	task automatic note_error(string what, pixel_t want, pixel_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: exp x=%0d y=%0d last=%0d st=%0d, got x=%0d y=%0d last=%0d st=%0d",
				$realtime, what, want.px, want.py, want.fin, want.status,
				got.px, got.py, got.fin, got.status);
	endtask

	// offer one item in a burst/gap pattern; returns once it is taken
	task automatic offer(line_cmd_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({it.yf, it.xf, it.yb, it.xb});
		s_tuser <= it.kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_checked(line_cmd_t it);
		offer(it);
		pixel_q.push_back(next_pixel(it));
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pixel_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic line_cmd_t rand_step();
		line_cmd_t it;
		it = line_cmd_t'({$urandom, $urandom});
		it.kind = CMD_STEP;
		return it;
	endfunction

	function automatic line_cmd_t rand_line();
		line_cmd_t it;
		int        span;
		int        rise;
		it.kind = CMD_START;
		it.xb = CW'($urandom_range(0, CMAX));
		it.yb = CW'($urandom_range(0, CMAX));
		span = ($urandom_range(0, 24) == 0) ? $urandom_range(0, CMAX) : $urandom_range(0, 12);
		if (int'(it.xb) + span > CMAX)
			span = CMAX - int'(it.xb);
		if ($urandom_range(0, 1) == 0)
			rise = $urandom_range(0, CMAX - int'(it.yb));
		else
			rise = $urandom_range(0, 2 * span + 1);
		if (int'(it.yb) + rise > CMAX)
			rise = CMAX - int'(it.yb);
		it.xf = CW'(int'(it.xb) + span);
		it.yf = CW'(int'(it.yb) + rise);
		return it;
	endfunction

	function automatic line_cmd_t rand_backward();
		line_cmd_t it;
		it.kind = CMD_START;
		it.xb = CW'($urandom_range(1, CMAX));
		it.yb = CW'($urandom_range(1, CMAX));
		it.xf = CW'($urandom_range(0, CMAX));
		it.yf = CW'($urandom_range(0, CMAX));
		if ($urandom_range(0, 1) == 0)
			it.xf = CW'($urandom_range(0, int'(it.xb) - 1));
		else
			it.yf = CW'($urandom_range(0, int'(it.yb) - 1));
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.px = m_tdata[CW-1:0];
			got.py = m_tdata[2*CW-1:CW];
			got.fin = m_tlast;
			got.status = m_tuser;
			if (pixel_q.size() == 0) begin
				note_error("unexpected item", '0, got);
			end else begin
				want = pixel_q.pop_front();
				if (got.px !== want.px || got.py !== want.py ||
					got.fin !== want.fin || got.status !== want.status)
					note_error("mismatch", want, got);
			end
		end
	end

	// receiver: a series of random ready duty patterns, plus one long hold-off on request
	initial begin
		int period;
		int duty;
		int cnt;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end
			period = $urandom_range(1, 8);
			duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(1, period);
			for (cnt = 0; cnt < 48; cnt++) begin
				m_tready <= ((cnt % period) < duty);
				@(posedge clk);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int        i;
		int        steps;
		int        sel;
		bit        held;
		bit        paused;
		line_cmd_t it;
		pixel_t    want;
		held = 1'b0;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			offer(DIR_TAB[i].it);
			want = next_pixel(DIR_TAB[i].it);
			if (DIR_TAB[i].typed)
				want = DIR_TAB[i].want;
			pixel_q.push_back(want);
		end
		drain_all();

		while (items_sent < DIR_N + RAND_ITEMS) begin
			if (!held && items_sent >= DIR_N + 500) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && items_sent >= DIR_N + 1000) begin
				paused = 1'b1;
				drain_all();
			end
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				it = rand_line();
				send_checked(it);
				steps = int'(it.xf) - int'(it.xb);
				case ($urandom_range(0, 5))
					0: steps = $urandom_range(0, steps);
					1: steps = steps + $urandom_range(1, 2);
					default: ;
				endcase
				repeat (steps) send_checked(rand_step());
			end else if (sel < 9) begin
				send_checked(rand_backward());
				if ($urandom_range(0, 1) == 0)
					send_checked(rand_step());
			end else begin
				send_checked(rand_step());
			end
		end

		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ddalr_pkg.sv
hw/rtl/ddalr_ctrl.sv
hw/rtl/ddalr_dpath.sv
hw/rtl/dda_line_rasterizer.sv
hw/rtl/ddalr_checker.sv
tb/tb.sv
